// ===== design/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// types, codes and byte classing shared by the source text lexer
// ----------------------------------------------------------------------------
package stl_pkg;

    // default width of the line, column and length counters
    localparam int POS_BITS_DEFAULT = 16;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int FIELD_W   = 16;
    localparam int KIND_W    = 3;
    localparam int M_TDATA_W = 56;

    // scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_NAME,
        MODE_DQ,
        MODE_SQ,
        MODE_P1,
        MODE_P2
    } scan_mode_t;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_NUM   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NAME  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DQ    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SQ    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PUNCT = 3'd4;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z))
            || (c == CH_UNDER);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || (c == CH_DOT);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT)
            || (c == CH_FF) || (c == CH_CR);
    endfunction

    // two-byte punctuation pairs
    function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
        logic r;
        unique case (a)
            CH_COLON:  r = (b == CH_EQ);
            CH_MINUS:  r = (b == CH_GT);
            CH_EQ:     r = (b == CH_EQ);
            CH_TILDE:  r = (b == CH_EQ);
            CH_LT:     r = (b == CH_EQ) || (b == CH_LT);
            CH_GT:     r = (b == CH_EQ) || (b == CH_GT);
            CH_AMP:    r = (b == CH_AMP);
            CH_BAR:    r = (b == CH_BAR);
            CH_CARET:  r = (b == CH_CARET);
            CH_SLASH:  r = (b == CH_STAR) || (b == CH_SLASH);
            CH_STAR:   r = (b == CH_SLASH) || (b == CH_LBRACK);
            CH_LBRACK: r = (b == CH_RBRACK);
            CH_DOT:    r = (b == CH_DOT);
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/source_text_lexer_core.sv =====
// ----------------------------------------------------------------------------
// source_text_lexer_core
// streaming lexer: splits source text bytes into number, name, string and
// punctuation tokens, dropping comments
// ----------------------------------------------------------------------------
// usage
//   input stream: one request per text byte, tdata holds the byte and tuser
//   marks end of text (flush, byte ignored). a flush reports the pending
//   token and returns the scanner to its reset state for the next text
//   output stream: one request per finished token with kind, line, column
//   and length; bytes that only extend a token, and comment tokens, give
//   no output request
//   a token is known complete only when the byte after it (or the flush)
//   arrives, so it leaves one accepted request later than its last byte
//   timing: the byte is classed against the scanner state combinationally and
//   the token lands in the output register on the accepting edge, so it is
//   visible the cycle after; one byte per cycle while tready is high, limited by
//   the single state update loop through the scanner registers
//   stalls: tready drops whenever a token waits in the output register and
//   the receiver is not taking it, even for a byte that would give no token
//   reset: scanner returns to idle at line 0 column 0, output empty
//   line, column and length saturate at 2^POSITION_BITS-1 and are reported
//   in their low 16 bits
// ----------------------------------------------------------------------------
module source_text_lexer_core #(
    parameter int POSITION_BITS = stl_pkg::POS_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [stl_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // char_code[7:0]
    input  logic                           s_axis_tuser,  // flush
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // token_kind[2:0], token_line[18:3], token_column[34:19],
    // token_length[50:35], zero fill[55:51]
    output logic [stl_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import stl_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_TWO = POSITION_BITS'(2);

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + POS_ONE;
    endfunction

    function automatic logic [POSITION_BITS-1:0] sat_add(input logic [POSITION_BITS-1:0] a,
                                                         input logic [POSITION_BITS-1:0] b);
        logic [POSITION_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POSITION_BITS] ? POS_MAX : s[POSITION_BITS-1:0];
    endfunction

    // scanner state
    scan_mode_t               mode_reg, mode_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [POSITION_BITS-1:0] len_reg, len_next;
    logic [7:0]               prev_reg, prev_next;
    logic [7:0]               pair_first_reg, pair_first_next;
    logic                     closed_reg, closed_next;
    logic                     held_dot_reg, held_dot_next;
    logic                     in_line_reg, in_line_next;
    logic                     in_block_reg, in_block_next;

    // output register
    logic                     out_valid_reg;
    logic [M_TDATA_W-1:0]     out_data_reg;

    logic [7:0]               c;
    logic                     flush;
    logic                     accept;
    logic                     dot_pair;
    logic                     fall_through;
    logic                     finish_now;
    logic                     is_p2;
    logic                     comment_marker;
    logic                     emit;
    logic [KIND_W-1:0]        kind;
    logic [POSITION_BITS-1:0] len_eff;
    logic                     closes;

    assign c      = s_axis_tdata;
    assign flush  = s_axis_tuser;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;

    assign is_p2 = (mode_reg == MODE_P2);

    // second dot after a name: name ends before the first dot
    assign dot_pair = !flush && (mode_reg == MODE_NAME) && held_dot_reg && (c == CH_DOT);

    // byte does not continue the pending token
    always_comb
    begin
        fall_through = 1'b1;
        case (mode_reg)
            MODE_NUM:
                fall_through = !(is_digit(c)
                                 || ((len_reg == POS_ONE) && ((c == CH_LO_X) || (c == CH_LO_B))));
            MODE_NAME:
                fall_through = (c != CH_DOT) && !is_name_char(c);
            MODE_DQ, MODE_SQ:
                fall_through = closed_reg;
            MODE_P1:
                fall_through = !is_pair(prev_reg, c);
            default:
                fall_through = 1'b1;
        endcase
        if (flush)
        begin
            fall_through = 1'b0;
        end
    end

    assign finish_now = flush || dot_pair || fall_through;

    // held dot joins the name unless a second dot follows
    assign len_eff = ((mode_reg == MODE_NAME) && held_dot_reg && (flush || (c != CH_DOT)))
                     ? sat_inc(len_reg) : len_reg;

    assign comment_marker = is_p2 && (pair_first_reg == CH_SLASH)
                            && ((prev_reg == CH_SLASH) || (prev_reg == CH_STAR));

    assign closes = (c == ((mode_reg == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE))
                    && (prev_reg != CH_BSLASH);

    // result side
    always_comb
    begin
        emit = finish_now && (mode_reg != MODE_IDLE) && !in_line_reg && !in_block_reg
               && !comment_marker;
        unique case (mode_reg)
            MODE_NUM:  kind = KIND_NUM;
            MODE_NAME: kind = KIND_NAME;
            MODE_DQ:   kind = KIND_DQ;
            MODE_SQ:   kind = KIND_SQ;
            default:   kind = KIND_PUNCT;
        endcase
    end

    // next scanner state
    always_comb
    begin
        mode_next       = mode_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        prev_next       = prev_reg;
        pair_first_next = pair_first_reg;
        closed_next     = closed_reg;
        held_dot_next   = held_dot_reg;
        in_line_next    = in_line_reg;
        in_block_next   = in_block_reg;

        if (flush)
        begin
            mode_next       = MODE_IDLE;
            line_next       = '0;
            col_next        = '0;
            start_next      = '0;
            len_next        = '0;
            prev_next       = '0;
            pair_first_next = '0;
            closed_next     = 1'b0;
            held_dot_next   = 1'b0;
            in_line_next    = 1'b0;
            in_block_next   = 1'b0;
        end
        else if (dot_pair)
        begin
            mode_next       = MODE_P2;
            start_next      = sat_add(start_reg, len_reg);
            len_next        = POS_TWO;
            pair_first_next = CH_DOT;
            prev_next       = CH_DOT;
            held_dot_next   = 1'b0;
            closed_next     = 1'b0;
            col_next        = sat_inc(col_reg);
        end
        else if (fall_through)
        begin
            // close the pending token, track comment markers
            if (!in_line_reg)
            begin
                if (in_block_reg)
                begin
                    if (is_p2 && (pair_first_reg == CH_STAR) && (prev_reg == CH_SLASH))
                    begin
                        in_block_next = 1'b0;
                    end
                end
                else if (is_p2 && (pair_first_reg == CH_SLASH) && (prev_reg == CH_SLASH))
                begin
                    in_line_next = 1'b1;
                end
                else if (is_p2 && (pair_first_reg == CH_SLASH) && (prev_reg == CH_STAR))
                begin
                    in_block_next = 1'b1;
                end
            end
            mode_next     = MODE_IDLE;
            held_dot_next = 1'b0;
            closed_next   = 1'b0;

            // start on the new byte
            if (is_space(c))
            begin
                if (c == CH_LF)
                begin
                    line_next    = sat_inc(line_reg);
                    col_next     = '0;
                    in_line_next = 1'b0;
                end
                else if (c != CH_CR)
                begin
                    col_next = sat_inc(col_reg);
                end
            end
            else
            begin
                start_next = col_reg;
                len_next   = POS_ONE;
                prev_next  = c;
                if (is_digit(c))
                begin
                    mode_next = MODE_NUM;
                end
                else if (is_letter(c))
                begin
                    mode_next = MODE_NAME;
                end
                else if (c == CH_DQUOTE)
                begin
                    mode_next = MODE_DQ;
                end
                else if (c == CH_SQUOTE)
                begin
                    mode_next = MODE_SQ;
                end
                else
                begin
                    mode_next = MODE_P1;
                end
                col_next = sat_inc(col_reg);
            end
        end
        else
        begin
            // byte continues the pending token
            case (mode_reg)
                MODE_NUM:
                begin
                    len_next  = sat_inc(len_reg);
                    prev_next = c;
                    col_next  = sat_inc(col_reg);
                end
                MODE_NAME:
                begin
                    if (c == CH_DOT)
                    begin
                        held_dot_next = 1'b1;
                        col_next      = sat_inc(col_reg);
                    end
                    else
                    begin
                        held_dot_next = 1'b0;
                        len_next      = sat_inc(len_eff);
                        prev_next     = c;
                        col_next      = sat_inc(col_reg);
                    end
                end
                MODE_DQ, MODE_SQ:
                begin
                    len_next    = sat_inc(len_reg);
                    prev_next   = c;
                    col_next    = sat_inc(col_reg);
                    closed_next = closes;
                end
                MODE_P1:
                begin
                    pair_first_next = prev_reg;
                    prev_next       = c;
                    len_next        = POS_TWO;
                    mode_next       = MODE_P2;
                    col_next        = sat_inc(col_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    // scanner registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            line_reg       <= '0;
            col_reg        <= '0;
            start_reg      <= '0;
            len_reg        <= '0;
            prev_reg       <= '0;
            pair_first_reg <= '0;
            closed_reg     <= 1'b0;
            held_dot_reg   <= 1'b0;
            in_line_reg    <= 1'b0;
            in_block_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            start_reg      <= start_next;
            len_reg        <= len_next;
            prev_reg       <= prev_next;
            pair_first_reg <= pair_first_next;
            closed_reg     <= closed_next;
            held_dot_reg   <= held_dot_next;
            in_line_reg    <= in_line_next;
            in_block_reg   <= in_block_next;
        end
    end

    // output request valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload, low 16 bits of each position field
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= {5'b0, FIELD_W'(len_eff), FIELD_W'(start_reg),
                             FIELD_W'(line_reg), kind};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a pending token always has a length
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_IDLE) |-> (len_reg != '0))
        else $error("pending token with zero length");

    // a held dot exists only behind a name
    a_held_dot_name: assert property (@(posedge clk) disable iff (!rst_n)
        held_dot_reg |-> (mode_reg == MODE_NAME))
        else $error("held dot outside a name");

    // a closed string flag only in string modes
    a_closed_string: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> ((mode_reg == MODE_DQ) || (mode_reg == MODE_SQ)))
        else $error("string closed flag outside a string");

    // line and block comment never open together
    a_one_comment: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_line_reg && in_block_reg))
        else $error("line and block comment both open");

    // flush restarts the scanner at the top of the text
    a_flush_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && flush) |=> ((mode_reg == MODE_IDLE) && (line_reg == '0) && (col_reg == '0)
                               && !in_line_reg && !in_block_reg))
        else $error("scanner not restarted after flush");

endmodule

// ===== tb/sv/source_text_lexer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_lexer_core_tb
// self-checking bench: text bytes go in as stream requests, a scanner model in
// the bench predicts every token and each output request is checked against it
// ----------------------------------------------------------------------------
module source_text_lexer_core_tb;
    import stl_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 10;
    localparam int POS_W        = POS_BITS_DEFAULT;
    localparam int RANDOM_ITEMS = 1390;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 150;     // tokens checked before the long hold-off
    localparam int DRAIN_CYCLES = 10;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_CAP    = 40;

    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TWO = POS_W'(2);

    // one text byte request waiting to be offered, with its idle cycles ahead
    typedef struct {
        logic [7:0]  code;
        logic        flush;
        int unsigned gap;
    } text_req_t;

    // one predicted token
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] column;
        logic [FIELD_W-1:0] length;
    } token_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    text_req_t   text_bytes[$];
    token_t      tokens_due[$];
    int unsigned bytes_queued   = 0;
    int unsigned bytes_taken    = 0;
    int unsigned tokens_checked = 0;
    int unsigned fault_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    int unsigned rx_wait        = 0;
    bit          rx_quiet       = 1'b0;
    bit          tx_idle        = 1'b1;

    // scanner model state
    scan_mode_t       lex_mode;
    logic [POS_W-1:0] at_line;
    logic [POS_W-1:0] at_col;
    logic [POS_W-1:0] tok_col;
    logic [POS_W-1:0] tok_len;
    logic [7:0]       last_byte;
    logic [7:0]       pair_lead;
    bit               quote_shut;
    bit               dot_held;
    bit               line_cmt;
    bit               block_cmt;

    logic [7:0] blanks [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    // two-byte punctuation, two characters per entry
    string pair_set = ":=->==~=<=>=<<>>&&||^^/*//*/*[[]..";

    source_text_lexer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // char_code[7:0]
        .s_axis_tuser  (s_axis_tuser),   // flush
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // token_kind[2:0], token_line[18:3], token_column[34:19],
        // token_length[50:35], zero fill[55:51]
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // byte classing
    // ------------------------------------------------------------------------
    function automatic bit digit_ch(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit word_start_ch(input logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)
            || c == CH_UNDER;
    endfunction

    function automatic bit word_ch(input logic [7:0] c);
        return word_start_ch(c) || digit_ch(c) || c == CH_DOT;
    endfunction

    function automatic bit blank_ch(input logic [7:0] c);
        bit hit;
        hit = 1'b0;
        foreach (blanks[i])
            if (blanks[i] == c)
                hit = 1'b1;
        return hit;
    endfunction

    function automatic bit forms_pair(input logic [7:0] a, input logic [7:0] b);
        bit hit;
        hit = 1'b0;
        for (int i = 0; i < pair_set.len(); i += 2)
            if (pair_set[i] == a && pair_set[i + 1] == b)
                hit = 1'b1;
        return hit;
    endfunction

    // position counters stop at all ones
    function automatic logic [POS_W-1:0] sat_sum(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = a + b;
        return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // scanner model
    // ------------------------------------------------------------------------
    task automatic clear_scanner();
        lex_mode   = MODE_IDLE;
        at_line    = '0;
        at_col     = '0;
        tok_col    = '0;
        tok_len    = '0;
        last_byte  = '0;
        pair_lead  = '0;
        quote_shut = 1'b0;
        dot_held   = 1'b0;
        line_cmt   = 1'b0;
        block_cmt  = 1'b0;
    endtask

    // closes the pending token; comment markers and commented-out tokens vanish
    task automatic close_token();
        token_t t;
        bit     pair;
        pair = lex_mode == MODE_P2;
        if (lex_mode == MODE_IDLE)
            return;
        if (line_cmt)
        begin
        end
        else if (block_cmt)
        begin
            if (pair && pair_lead == CH_STAR && last_byte == CH_SLASH)
                block_cmt = 1'b0;
        end
        else if (pair && pair_lead == CH_SLASH && last_byte == CH_SLASH)
            line_cmt = 1'b1;
        else if (pair && pair_lead == CH_SLASH && last_byte == CH_STAR)
            block_cmt = 1'b1;
        else
        begin
            case (lex_mode)
                MODE_NUM:  t.kind = KIND_NUM;
                MODE_NAME: t.kind = KIND_NAME;
                MODE_DQ:   t.kind = KIND_DQ;
                MODE_SQ:   t.kind = KIND_SQ;
                default:   t.kind = KIND_PUNCT;
            endcase
            t.line   = at_line[FIELD_W-1:0];
            t.column = tok_col[FIELD_W-1:0];
            t.length = tok_len[FIELD_W-1:0];
            tokens_due = {tokens_due, t};
        end
        lex_mode   = MODE_IDLE;
        dot_held   = 1'b0;
        quote_shut = 1'b0;
    endtask

    task automatic grow_token(input logic [7:0] c);
        tok_len   = sat_sum(tok_len, POS_ONE);
        last_byte = c;
        at_col    = sat_sum(at_col, POS_ONE);
    endtask

    task automatic open_token(input logic [7:0] c);
        if (blank_ch(c))
        begin
            if (c == CH_LF)
            begin
                at_line  = sat_sum(at_line, POS_ONE);
                at_col   = '0;
                line_cmt = 1'b0;
            end
            else if (c != CH_CR)
                at_col = sat_sum(at_col, POS_ONE);
            return;
        end
        tok_col    = at_col;
        tok_len    = POS_ONE;
        last_byte  = c;
        quote_shut = 1'b0;
        dot_held   = 1'b0;
        if (digit_ch(c))
            lex_mode = MODE_NUM;
        else if (word_start_ch(c))
            lex_mode = MODE_NAME;
        else if (c == CH_DQUOTE)
            lex_mode = MODE_DQ;
        else if (c == CH_SQUOTE)
            lex_mode = MODE_SQ;
        else
            lex_mode = MODE_P1;
        at_col = sat_sum(at_col, POS_ONE);
    endtask

    // predicts the token (if any) that one accepted request releases
    task automatic lex_byte(input logic [7:0] c, input logic flush);
        logic [POS_W-1:0] dot_col;
        logic [7:0]       quote;
        bit               shuts;
        if (flush)
        begin
            if (lex_mode == MODE_NAME && dot_held)
                tok_len = sat_sum(tok_len, POS_ONE);
            close_token();
            clear_scanner();
            return;
        end
        case (lex_mode)
            MODE_NUM:
            begin
                if (digit_ch(c) || (tok_len == POS_ONE && (c == CH_LO_X || c == CH_LO_B)))
                begin
                    grow_token(c);
                    return;
                end
            end
            MODE_NAME:
            begin
                if (dot_held)
                begin
                    // second dot: name ends before the first, dots pair up
                    if (c == CH_DOT)
                    begin
                        dot_col = sat_sum(tok_col, tok_len);
                        close_token();
                        lex_mode  = MODE_P2;
                        tok_col   = dot_col;
                        tok_len   = POS_TWO;
                        pair_lead = CH_DOT;
                        last_byte = CH_DOT;
                        at_col    = sat_sum(at_col, POS_ONE);
                        return;
                    end
                    tok_len  = sat_sum(tok_len, POS_ONE);
                    dot_held = 1'b0;
                end
                if (c == CH_DOT)
                begin
                    dot_held = 1'b1;
                    at_col   = sat_sum(at_col, POS_ONE);
                    return;
                end
                if (word_ch(c))
                begin
                    grow_token(c);
                    return;
                end
            end
            MODE_DQ, MODE_SQ:
            begin
                if (!quote_shut)
                begin
                    quote = (lex_mode == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE;
                    shuts = c == quote && last_byte != CH_BSLASH;
                    grow_token(c);
                    quote_shut = shuts;
                    return;
                end
            end
            MODE_P1:
            begin
                if (forms_pair(last_byte, c))
                begin
                    pair_lead = last_byte;
                    last_byte = c;
                    tok_len   = POS_TWO;
                    lex_mode  = MODE_P2;
                    at_col    = sat_sum(at_col, POS_ONE);
                    return;
                end
            end
            default:
            begin
            end
        endcase
        close_token();
        open_token(c);
    endtask

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] code, input logic flush);
        text_req_t r;
        r.code  = code;
        r.flush = flush;
        r.gap   = tx_idle ? $urandom_range(0, 11) : 0;
        text_bytes = {text_bytes, r};
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endtask

    // byte ignored on a flush, so any value goes
    task automatic push_flush();
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] pick(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // one well-formed piece of source text with random content, or noise
    task automatic add_fragment();
        int unsigned n;
        logic [7:0]  quote;
        if ($urandom_range(0, 15) == 0)
            tx_idle = !tx_idle;
        case ($urandom_range(0, 11))
            0, 1:
            begin
                push_byte(pick("0123456789"), 1'b0);
                if ($urandom_range(0, 2) == 0)
                    push_byte($urandom_range(0, 1) ? CH_LO_X : CH_LO_B, 1'b0);
                repeat ($urandom_range(0, 4))
                    push_byte(pick("0123456789"), 1'b0);
            end
            2, 3:
            begin
                push_byte(pick("abqzAQZ_"), 1'b0);
                repeat ($urandom_range(0, 5))
                    push_byte(pick("az09_Q."), 1'b0);
                if ($urandom_range(0, 3) == 0)
                    push_text("..");
            end
            4:
            begin
                quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                push_byte(quote, 1'b0);
                repeat ($urandom_range(0, 5))
                begin
                    if ($urandom_range(0, 5) == 0)
                        push_byte(CH_LF, 1'b0);
                    else
                        push_byte(pick("a \\\"'/*"), 1'b0);
                end
                if ($urandom_range(0, 3) != 0)
                    push_byte(quote, 1'b0);
            end
            5, 6:
            begin
                n = 2 * $urandom_range(0, pair_set.len() / 2 - 1);
                push_byte(pair_set[n], 1'b0);
                push_byte(pair_set[n + 1], 1'b0);
            end
            7:
                push_byte(pick("+-*/=<>:~&|^[].;,(){}!@#$%?"), 1'b0);
            8:
            begin
                push_text("//");
                repeat ($urandom_range(0, 6))
                    push_byte(pick("a1/*\"' ."), 1'b0);
                if ($urandom_range(0, 3) != 0)
                    push_byte(CH_LF, 1'b0);
            end
            9:
            begin
                push_text("/*");
                repeat ($urandom_range(0, 8))
                begin
                    if ($urandom_range(0, 4) == 0)
                        push_byte(CH_LF, 1'b0);
                    else
                        push_byte(pick("a//* 1\"'"), 1'b0);
                end
                if ($urandom_range(0, 5) != 0)
                    push_text("*/");
            end
            10:
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            default:
            begin
                if ($urandom_range(0, 2) == 0)
                    push_flush();
                else
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        endcase
        // separator half of the time, otherwise fragments run into each other
        if ($urandom_range(0, 1) == 0)
            push_byte(blanks[$urandom_range(0, 5)], 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_fault(input string what);
        fault_count++;
        if (fault_count <= PRINT_CAP)
            $display("ERROR @%0t: %s", $time, what);
    endtask

    task automatic check_token(input logic [M_TDATA_W-1:0] word);
        token_t due;
        if (tokens_due.size() == 0)
        begin
            report_fault($sformatf("token 0x%h with none expected", word));
            return;
        end
        due = tokens_due.pop_front();
        if (word[2:0] != due.kind)
            report_fault($sformatf("kind %0d, expected %0d", word[2:0], due.kind));
        if (word[18:3] != due.line)
            report_fault($sformatf("line %0d, expected %0d", word[18:3], due.line));
        if (word[34:19] != due.column)
            report_fault($sformatf("column %0d, expected %0d", word[34:19], due.column));
        if (word[50:35] != due.length)
            report_fault($sformatf("length %0d, expected %0d", word[50:35], due.length));
        if (word[55:51] != '0)
            report_fault($sformatf("zero fill holds 0x%h", word[55:51]));
    endtask

    // ------------------------------------------------------------------------
    // input driver: offers queued bytes, predicts each one on acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                lex_byte(s_axis_tdata, s_axis_tuser);
                bytes_taken++;
            end
            // the bus is free for a new request once the held one is taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (text_bytes.size() != 0 && text_bytes[0].gap == 0)
                begin
                    s_axis_tdata  <= text_bytes[0].code;
                    s_axis_tuser  <= text_bytes[0].flush;
                    s_axis_tvalid <= 1'b1;
                    void'(text_bytes.pop_front());
                end
                else
                begin
                    if (text_bytes.size() != 0)
                        text_bytes[0].gap = text_bytes[0].gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output monitor: checks each taken token, draws its own stalls
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_token(m_axis_tdata);
                tokens_checked <= tokens_checked + 1;
                // alternate stretches of random stalls with stall-free ones
                if (tokens_checked % 40 == 39)
                    rx_quiet = !rx_quiet;
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 11);
            end
            else if (rx_wait != 0)
                rx_wait--;
            m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // one long hold-off on the output so the block backs up onto its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (!hold_done && tokens_checked >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // overall run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("source_text_lexer_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence: build the whole text up front, release reset, wait for drain
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned drain_left;
        int unsigned random_base;
        clear_scanner();

        // number prefixes, held dot, dot pair after a name, trailing dot at flush
        push_text("0b1 9x a_Z.q..r.");
        push_flush();
        // escaped quote, newline inside a string, open string ended by flush
        push_text("\"a\\\"");
        push_byte(CH_LF, 1'b0);
        push_text("\" 'b");
        push_flush();
        // comments, markers inside comments, every blank, extreme byte values,
        // lone punctuation at flush
        push_text("//c/*");
        push_byte(CH_LF, 1'b0);
        push_text("/*/ d//*/*[ ");
        push_byte(CH_CR, 1'b0);
        push_byte(CH_TAB, 1'b0);
        push_byte(CH_VT, 1'b0);
        push_byte(CH_FF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_text("<");
        push_flush();
        // block comment still open at flush
        push_text("x /* y");
        push_flush();

        // random source text
        random_base = bytes_queued;
        while (bytes_queued - random_base < RANDOM_ITEMS)
            add_fragment();
        push_flush();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken != bytes_queued)
            @(negedge clk);
        drain_left = DRAIN_LIMIT;
        while (tokens_due.size() != 0 && drain_left != 0)
        begin
            @(negedge clk);
            drain_left--;
        end
        if (tokens_due.size() != 0)
            report_fault($sformatf("%0d tokens never arrived", tokens_due.size()));
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fault_count == 0)
            $display("source_text_lexer_core regression: pass");
        else
            $display("source_text_lexer_core regression: fail");
        $finish;
    end

endmodule
